// File: design/slaaq_pkg.sv
package slaaq_pkg;

    localparam int unsigned TimeWidth = 32;
    localparam int unsigned LenWidth  = 16;
    localparam int unsigned TolWidth  = 15;
    localparam int unsigned CfgIdxWidth = 3;
    localparam int unsigned CfgDataWidth = 16;
    localparam int unsigned InDataWidth = 56;
    localparam int unsigned OutDataWidth = 24;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_STABLE_TIME = 3'd0,
        CFG_TOLERANCE   = 3'd1,
        CFG_MIN_LENGTH  = 3'd2,
        CFG_MAX_LENGTH  = 3'd3,
        CFG_MIN_GAP     = 3'd4,
        CFG_CLEAR_LEVEL = 3'd5,
        CFG_CLEAR_TIME  = 3'd6
    } cfg_index_t;

    localparam logic [15:0]        RstStableTime = 16'd100;
    localparam logic [14:0]        RstTolerance  = 15'd64;
    localparam logic signed [15:0] RstMinLength  = 16'sd256;
    localparam logic signed [15:0] RstMaxLength  = 16'sd2816;
    localparam logic [15:0]        RstMinGap     = 16'd300;
    localparam logic signed [15:0] RstClearLevel = 16'sd0;
    localparam logic [15:0]        RstClearTime  = 16'd200;

    localparam logic OpSample  = 1'b0;
    localparam logic OpRestart = 1'b1;

endpackage

// File: design/stable_length_auto_add_qualifier_top.sv
// Channel  Direction  Signals                        Payload
// s        in         s_tvalid s_tready s_tdata      tdata: now_ms[31:0] reading_valid[32]
//                     s_tuser                        length_q8[48:33]; tuser: op
// m        out        m_tvalid m_tready m_tdata      tdata: added_length_q8[15:0]
//                     m_tuser                        tracking[16] clear_seen[17]; tuser: add_event
// cfg      in         cfg_valid cfg_ready            cfg_index, cfg_data (always ready)
//
// Each beat is captured in the input register and then moves to the result register, which
// offers its result; one beat is taken per cycle while the output is not stalled.
// The gating state is updated as an item moves from the input to the result register.
// A stalled output holds both registers; ready drops only when both are full and
// m_tready is low.
// Reset is asynchronous and active low and restores the register defaults.
module stable_length_auto_add_qualifier_top
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // now_ms[31:0], reading_valid[32], length_q8[48:33], zeros above
    input  logic [slaaq_pkg::InDataWidth-1:0]    s_tdata,
    // op[0]
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // added_length_q8[15:0], tracking[16], clear_seen[17], zeros above
    output logic [slaaq_pkg::OutDataWidth-1:0]   m_tdata,
    // add_event[0]
    output logic                                 m_tuser,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [slaaq_pkg::CfgIdxWidth-1:0]    cfg_index,
    input  logic [slaaq_pkg::CfgDataWidth-1:0]   cfg_data
);

    logic [15:0]        stable_time_reg;
    logic [14:0]        tolerance_reg;
    logic signed [15:0] min_length_reg;
    logic signed [15:0] max_length_reg;
    logic [15:0]        min_gap_reg;
    logic signed [15:0] clear_level_reg;
    logic [15:0]        clear_time_reg;

    logic               in_valid_reg;
    logic               in_op_reg;
    logic [31:0]        in_now_reg;
    logic               in_rv_reg;
    logic signed [15:0] in_len_reg;

    logic               out_valid_reg;
    logic               out_add_reg;
    logic signed [15:0] out_len_reg;
    logic               out_track_reg;
    logic               out_clear_reg;

    logic signed [15:0] ref_len_reg, ref_len_next;
    logic [31:0]        stable_start_reg, stable_start_next;
    logic               stable_active_reg, stable_active_next;
    logic [31:0]        last_add_reg, last_add_next;
    logic               added_once_reg, added_once_next;
    logic [31:0]        clear_start_reg, clear_start_next;
    logic               clear_active_reg, clear_active_next;
    logic               clear_done_reg, clear_done_next;

    logic               add_next;
    logic               advance;
    logic               is_clear;
    logic               in_range;
    logic               clear_done_mid;
    logic               clear_ok;
    logic [31:0]        clear_elapsed;
    logic [31:0]        stable_elapsed;
    logic [31:0]        gap_elapsed;
    logic signed [16:0] len_diff;
    logic [16:0]        abs_diff;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tuser   = out_add_reg;
    assign m_tdata   = {6'b0, out_clear_reg, out_track_reg, out_len_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_time_reg <= slaaq_pkg::RstStableTime;
            tolerance_reg   <= slaaq_pkg::RstTolerance;
            min_length_reg  <= slaaq_pkg::RstMinLength;
            max_length_reg  <= slaaq_pkg::RstMaxLength;
            min_gap_reg     <= slaaq_pkg::RstMinGap;
            clear_level_reg <= slaaq_pkg::RstClearLevel;
            clear_time_reg  <= slaaq_pkg::RstClearTime;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                slaaq_pkg::CFG_STABLE_TIME: stable_time_reg <= cfg_data;
                slaaq_pkg::CFG_TOLERANCE:   tolerance_reg   <= cfg_data[14:0];
                slaaq_pkg::CFG_MIN_LENGTH:  min_length_reg  <= cfg_data;
                slaaq_pkg::CFG_MAX_LENGTH:  max_length_reg  <= cfg_data;
                slaaq_pkg::CFG_MIN_GAP:     min_gap_reg     <= cfg_data;
                slaaq_pkg::CFG_CLEAR_LEVEL: clear_level_reg <= cfg_data;
                slaaq_pkg::CFG_CLEAR_TIME:  clear_time_reg  <= cfg_data;
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg  <= s_tuser;
            in_now_reg <= s_tdata[31:0];
            in_rv_reg  <= s_tdata[32];
            in_len_reg <= s_tdata[48:33];
        end
    end

    assign is_clear       = in_rv_reg && (in_len_reg <= clear_level_reg);
    assign in_range       = (in_len_reg >= min_length_reg) && (in_len_reg <= max_length_reg);
    assign clear_elapsed  = clear_active_reg ? (in_now_reg - clear_start_reg) : 32'd0;
    assign clear_done_mid = clear_done_reg
                            || (is_clear && (clear_elapsed >= {16'b0, clear_time_reg}));
    assign clear_ok       = !added_once_reg || clear_done_mid;
    assign stable_elapsed = in_now_reg - stable_start_reg;
    assign gap_elapsed    = in_now_reg - last_add_reg;
    assign len_diff       = {in_len_reg[15], in_len_reg} - {ref_len_reg[15], ref_len_reg};
    assign abs_diff       = len_diff[16] ? 17'(-len_diff) : 17'(len_diff);

    always_comb
    begin
        ref_len_next       = ref_len_reg;
        stable_start_next  = stable_start_reg;
        stable_active_next = stable_active_reg;
        last_add_next      = last_add_reg;
        added_once_next    = added_once_reg;
        clear_start_next   = clear_start_reg;
        clear_active_next  = clear_active_reg;
        clear_done_next    = clear_done_reg;
        add_next           = 1'b0;

        if (in_op_reg == slaaq_pkg::OpRestart)
        begin
            stable_active_next = 1'b0;
            added_once_next    = 1'b0;
            clear_active_next  = 1'b0;
            clear_done_next    = 1'b0;
        end
        else
        begin
            clear_active_next = is_clear;
            clear_done_next   = clear_done_mid;
            if (is_clear && !clear_active_reg)
            begin
                clear_start_next = in_now_reg;
            end

            if (in_rv_reg && in_range && clear_ok)
            begin
                if (!stable_active_reg)
                begin
                    ref_len_next       = in_len_reg;
                    stable_start_next  = in_now_reg;
                    stable_active_next = 1'b1;
                end
                else if (abs_diff <= {2'b0, tolerance_reg})
                begin
                    if ((stable_elapsed >= {16'b0, stable_time_reg})
                        && (!added_once_reg || (gap_elapsed >= {16'b0, min_gap_reg})))
                    begin
                        add_next           = 1'b1;
                        last_add_next      = in_now_reg;
                        added_once_next    = 1'b1;
                        clear_done_next    = 1'b0;
                        clear_active_next  = 1'b0;
                        stable_active_next = 1'b0;
                    end
                end
                else
                begin
                    ref_len_next      = in_len_reg;
                    stable_start_next = in_now_reg;
                end
            end
            else
            begin
                stable_active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_len_reg       <= '0;
            stable_start_reg  <= '0;
            stable_active_reg <= 1'b0;
            last_add_reg      <= '0;
            added_once_reg    <= 1'b0;
            clear_start_reg   <= '0;
            clear_active_reg  <= 1'b0;
            clear_done_reg    <= 1'b0;
        end
        else if (advance)
        begin
            ref_len_reg       <= ref_len_next;
            stable_start_reg  <= stable_start_next;
            stable_active_reg <= stable_active_next;
            last_add_reg      <= last_add_next;
            added_once_reg    <= added_once_next;
            clear_start_reg   <= clear_start_next;
            clear_active_reg  <= clear_active_next;
            clear_done_reg    <= clear_done_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_add_reg   <= add_next;
            out_len_reg   <= add_next ? in_len_reg : 16'sd0;
            out_track_reg <= stable_active_next;
            out_clear_reg <= clear_done_next;
        end
    end

endmodule

// File: design/slaaq_checker.sv
module slaaq_checker
(
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [slaaq_pkg::OutDataWidth-1:0]   m_tdata,
    input logic                                 m_tuser
);

    // A stalled result beat must hold its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Stalled result beat changed.");

    // A beat without an add carries a zero length.
    a_no_add_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[15:0] == 16'd0)
        else $error("Length reported without an add.");

    // An add stops tracking.
    a_add_stops_track: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> !m_tdata[16])
        else $error("Tracking still set after an add.");

    // An add resets the clear qualification.
    a_add_drops_clear: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> !m_tdata[17])
        else $error("Clear still seen after an add.");

endmodule

bind stable_length_auto_add_qualifier_top slaaq_checker u_slaaq_checker (.*);

// File: tb/sv/stable_length_auto_add_qualifier_top_test.sv
`timescale 1ns / 1ps

module stable_length_auto_add_qualifier_top_test;

    localparam int NumRows       = 21;
    localparam int NumPhases     = 8;
    localparam int ItemsPerPhase = 155;
    localparam int StallLimit    = 1000;

    localparam int PhaseFloor      = 0;
    localparam int PhaseCeiling    = 1;
    localparam int PhaseEmptyRange = 2;
    localparam int PhaseOverlap    = 3;

    localparam logic [slaaq_pkg::CfgIdxWidth-1:0] CfgUnusedIndex = 3'd7;

    typedef struct packed {
        logic        add_event;
        logic [15:0] added_length;
        logic        tracking;
        logic        clear_seen;
    } board_result_t;

    typedef struct {
        logic               op;
        logic [31:0]        now_ms;
        logic               reading_valid;
        logic signed [15:0] length_q8;
    } sample_t;

    typedef struct packed {
        logic          listed;
        board_result_t value;
    } listed_note_t;

    typedef struct packed {
        logic          op;
        logic [31:0]   now_ms;
        logic          reading_valid;
        logic [15:0]   length_q8;
        logic          listed;
        board_result_t result;
    } stim_row_t;

    localparam board_result_t NoResult = '0;

    // Rows with listed = 1 carry the result expected from the rules alone.
    localparam stim_row_t StimTable [NumRows] = '{
        '{slaaq_pkg::OpSample, 32'h0000_0000, 1'b1, 16'd512, 1'b1, '{1'b0, 16'd0, 1'b1, 1'b0}},
        '{slaaq_pkg::OpSample, 32'h0000_0032, 1'b1, 16'd520, 1'b0, NoResult},
        '{slaaq_pkg::OpSample, 32'h0000_0064, 1'b1, 16'd540, 1'b1, '{1'b1, 16'd540, 1'b0, 1'b0}},
        '{slaaq_pkg::OpSample, 32'h0000_0096, 1'b1, 16'd540, 1'b0, NoResult},
        '{slaaq_pkg::OpSample, 32'h0000_00C8, 1'b1, 16'd0, 1'b0, NoResult},
        '{slaaq_pkg::OpSample, 32'h0000_0190, 1'b1, 16'h8000, 1'b1, '{1'b0, 16'd0, 1'b0, 1'b1}},
        '{slaaq_pkg::OpSample, 32'h0000_01C2, 1'b1, 16'h7FFF, 1'b0, NoResult},
        '{slaaq_pkg::OpSample, 32'h0000_01F4, 1'b1, 16'd2816, 1'b0, NoResult},
        '{slaaq_pkg::OpSample, 32'h0000_0258, 1'b1, 16'd2816, 1'b1,
          '{1'b1, 16'd2816, 1'b0, 1'b0}},
        '{slaaq_pkg::OpSample, 32'h0000_0262, 1'b0, 16'd0, 1'b0, NoResult},
        '{slaaq_pkg::OpRestart, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 1'b1,
          '{1'b0, 16'd0, 1'b0, 1'b0}},
        '{slaaq_pkg::OpSample, 32'hFFFF_FFF0, 1'b1, 16'd256, 1'b0, NoResult},
        '{slaaq_pkg::OpSample, 32'h0000_0060, 1'b1, 16'd320, 1'b0, NoResult},
        '{slaaq_pkg::OpSample, 32'h0000_0010, 1'b1, 16'd0, 1'b0, NoResult},
        '{slaaq_pkg::OpSample, 32'h0000_0005, 1'b1, 16'd0, 1'b0, NoResult},
        '{slaaq_pkg::OpSample, 32'h0000_0030, 1'b1, 16'd255, 1'b0, NoResult},
        '{slaaq_pkg::OpSample, 32'h0000_0040, 1'b1, 16'd1000, 1'b0, NoResult},
        '{slaaq_pkg::OpSample, 32'h0000_0050, 1'b1, 16'd1065, 1'b0, NoResult},
        '{slaaq_pkg::OpSample, 32'h0000_00C0, 1'b1, 16'd1065, 1'b0, NoResult},
        '{slaaq_pkg::OpSample, 32'h0000_0200, 1'b1, 16'd1065, 1'b0, NoResult},
        '{slaaq_pkg::OpSample, 32'h0000_0210, 1'b0, 16'h8000, 1'b0, NoResult}
    };

    logic                               clk;
    logic                               rst_n;
    logic                               s_tvalid;
    logic                               s_tready;
    logic [slaaq_pkg::InDataWidth-1:0]  s_tdata;
    logic                               s_tuser;
    logic                               m_tvalid;
    logic                               m_tready;
    logic [slaaq_pkg::OutDataWidth-1:0] m_tdata;
    logic                               m_tuser;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [slaaq_pkg::CfgIdxWidth-1:0]  cfg_index;
    logic [slaaq_pkg::CfgDataWidth-1:0] cfg_data;

    logic [15:0]        set_stable_ms;
    logic [14:0]        set_tol;
    logic signed [15:0] set_min_len;
    logic signed [15:0] set_max_len;
    logic [15:0]        set_gap_ms;
    logic signed [15:0] set_clear_level;
    logic [15:0]        set_clear_ms;

    logic signed [15:0] base_len;
    logic [31:0]        stable_since;
    logic               stable_on;
    logic [31:0]        last_add_ms;
    logic               added_before;
    logic [31:0]        clear_since;
    logic               clear_on;
    logic               clear_latched;

    board_result_t board_results_due [$];
    listed_note_t  listed_notes [$];
    int            mismatches;
    int            quiet_cycles;
    bit            s_steady;
    bit            m_steady;

    stable_length_auto_add_qualifier_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void reset_qualifier_model();
        set_stable_ms   = slaaq_pkg::RstStableTime;
        set_tol         = slaaq_pkg::RstTolerance;
        set_min_len     = slaaq_pkg::RstMinLength;
        set_max_len     = slaaq_pkg::RstMaxLength;
        set_gap_ms      = slaaq_pkg::RstMinGap;
        set_clear_level = slaaq_pkg::RstClearLevel;
        set_clear_ms    = slaaq_pkg::RstClearTime;
        base_len        = '0;
        stable_since    = '0;
        stable_on       = 1'b0;
        last_add_ms     = '0;
        added_before    = 1'b0;
        clear_since     = '0;
        clear_on        = 1'b0;
        clear_latched   = 1'b0;
    endfunction

    function automatic void apply_setting(input logic [slaaq_pkg::CfgIdxWidth-1:0] idx,
                                          input logic [15:0] data);
        case (idx)
            slaaq_pkg::CFG_STABLE_TIME: set_stable_ms   = data;
            slaaq_pkg::CFG_TOLERANCE:   set_tol         = data[14:0];
            slaaq_pkg::CFG_MIN_LENGTH:  set_min_len     = data;
            slaaq_pkg::CFG_MAX_LENGTH:  set_max_len     = data;
            slaaq_pkg::CFG_MIN_GAP:     set_gap_ms      = data;
            slaaq_pkg::CFG_CLEAR_LEVEL: set_clear_level = data;
            slaaq_pkg::CFG_CLEAR_TIME:  set_clear_ms    = data;
            default: ;
        endcase
    endfunction

    function automatic board_result_t qualify_sample(input sample_t smp);
        board_result_t res;
        logic          clear_ok;
        int            delta;
        res = '0;
        if (smp.op == slaaq_pkg::OpRestart)
        begin
            stable_on     = 1'b0;
            added_before  = 1'b0;
            clear_on      = 1'b0;
            clear_latched = 1'b0;
            return res;
        end
        if (smp.reading_valid && smp.length_q8 <= set_clear_level)
        begin
            if (!clear_on)
            begin
                clear_on    = 1'b1;
                clear_since = smp.now_ms;
            end
            if (smp.now_ms - clear_since >= {16'd0, set_clear_ms})
                clear_latched = 1'b1;
        end
        else
            clear_on = 1'b0;
        clear_ok = !added_before || clear_latched;
        if (smp.reading_valid && smp.length_q8 >= set_min_len &&
            smp.length_q8 <= set_max_len && clear_ok)
        begin
            if (!stable_on)
            begin
                base_len     = smp.length_q8;
                stable_since = smp.now_ms;
                stable_on    = 1'b1;
            end
            else
            begin
                delta = int'(smp.length_q8) - int'(base_len);
                if (delta < 0)
                    delta = -delta;
                if (delta <= int'(set_tol))
                begin
                    if ((smp.now_ms - stable_since >= {16'd0, set_stable_ms}) &&
                        (!added_before || (smp.now_ms - last_add_ms >= {16'd0, set_gap_ms})))
                    begin
                        res.add_event    = 1'b1;
                        res.added_length = smp.length_q8;
                        last_add_ms      = smp.now_ms;
                        added_before     = 1'b1;
                        clear_latched    = 1'b0;
                        clear_on         = 1'b0;
                        stable_on        = 1'b0;
                    end
                end
                else
                begin
                    base_len     = smp.length_q8;
                    stable_since = smp.now_ms;
                end
            end
        end
        else
            stable_on = 1'b0;
        res.tracking   = stable_on;
        res.clear_seen = clear_latched;
        return res;
    endfunction

    function automatic int rand_between(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic logic [15:0] clamp16(input int v);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return 16'(v);
    endfunction

    task automatic send_item(input logic op, input logic [31:0] now_ms,
                             input logic reading_valid, input logic [15:0] length_q8,
                             input logic listed, input board_result_t listed_value);
        int hold;
        hold = s_steady ? 0 : int'($urandom_range(0, 3));
        if ($urandom_range(0, 29) == 0)
            s_steady = !s_steady;
        @(negedge clk);
        if (hold != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (hold) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, length_q8, reading_valid, now_ms};
        s_tuser  <= op;
        listed_notes.push_back('{listed, listed_value});
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic settle_input();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (board_results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [slaaq_pkg::CfgIdxWidth-1:0] idx,
                             input logic [15:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        apply_setting(idx, data);
    endtask

    task automatic load_settings(input int phase);
        logic [15:0] stable_ms;
        logic [15:0] tol_word;
        logic [15:0] min_len;
        logic [15:0] max_len;
        logic [15:0] gap_ms;
        logic [15:0] clear_level;
        logic [15:0] clear_ms;
        stable_ms   = 16'($urandom_range(0, 500));
        tol_word    = {1'($urandom_range(0, 1)), 15'($urandom_range(0, 200))};
        min_len     = clamp16(rand_between(-1000, 2000));
        max_len     = clamp16(int'($signed(min_len)) + rand_between(0, 3000));
        gap_ms      = 16'($urandom_range(0, 800));
        clear_level = clamp16(int'($signed(min_len)) - rand_between(1, 600));
        clear_ms    = 16'($urandom_range(0, 500));
        case (phase)
            PhaseFloor:
            begin
                stable_ms   = 16'h0000;
                tol_word    = 16'h0000;
                min_len     = 16'h8000;
                max_len     = 16'h8000;
                gap_ms      = 16'h0000;
                clear_level = 16'h8000;
                clear_ms    = 16'h0000;
            end
            PhaseCeiling:
            begin
                stable_ms   = 16'hFFFF;
                tol_word    = 16'hFFFF;
                min_len     = 16'h7FFF;
                max_len     = 16'h7FFF;
                gap_ms      = 16'hFFFF;
                clear_level = 16'h7FFF;
                clear_ms    = 16'hFFFF;
            end
            PhaseEmptyRange:
            begin
                min_len = 16'd2000;
                max_len = 16'd1000;
            end
            PhaseOverlap:
            begin
                min_len     = 16'd256;
                max_len     = 16'd2816;
                clear_level = 16'd1000;
            end
            default: ;
        endcase
        write_reg(slaaq_pkg::CFG_STABLE_TIME, stable_ms);
        write_reg(slaaq_pkg::CFG_TOLERANCE, tol_word);
        write_reg(slaaq_pkg::CFG_MIN_LENGTH, min_len);
        write_reg(slaaq_pkg::CFG_MAX_LENGTH, max_len);
        write_reg(slaaq_pkg::CFG_MIN_GAP, gap_ms);
        write_reg(slaaq_pkg::CFG_CLEAR_LEVEL, clear_level);
        write_reg(slaaq_pkg::CFG_CLEAR_TIME, clear_ms);
        write_reg(CfgUnusedIndex, 16'($urandom()));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // A phase is a run of boards: a stretch of readings near one length, then a
    // stretch of clear readings, with noise and restarts mixed in.
    task automatic run_random_phase(input int count);
        int          sent;
        int          span;
        int          base;
        int          roll;
        int          len_val;
        logic [31:0] clock_ms;
        sent = 0;
        span = int'(set_stable_ms);
        if (int'(set_gap_ms) > span)
            span = int'(set_gap_ms);
        if (int'(set_clear_ms) > span)
            span = int'(set_clear_ms);
        span = span / 2 + 2;
        if ($urandom_range(0, 3) == 0)
            clock_ms = 32'hFFFF_FFFF - $urandom_range(0, span * 4);
        else
            clock_ms = $urandom();
        while (sent < count)
        begin
            if (set_min_len <= set_max_len)
                base = rand_between(int'(set_min_len), int'(set_max_len));
            else
                base = rand_between(-32768, 32767);
            for (int part = 0; part < 2; part++)
            begin
                repeat ($urandom_range(2, 8))
                begin
                    clock_ms = clock_ms + $urandom_range(0, span);
                    roll     = int'($urandom_range(0, 99));
                    if (part == 0)
                        len_val = base + rand_between(-int'(set_tol) - 8, int'(set_tol) + 8);
                    else
                        len_val = int'(set_clear_level) - int'($urandom_range(0, 40));
                    if (roll < 8)
                        send_item(1'($urandom_range(0, 1)), $urandom(),
                                  1'($urandom_range(0, 1)), 16'($urandom()), 1'b0, NoResult);
                    else if (roll < 10)
                        send_item(slaaq_pkg::OpRestart, $urandom(), 1'($urandom_range(0, 1)),
                                  clamp16(len_val), 1'b0, NoResult);
                    else
                        send_item(slaaq_pkg::OpSample, clock_ms, roll >= 13, clamp16(len_val),
                                  1'b0, NoResult);
                    sent++;
                end
            end
        end
    endtask

    always @(posedge clk)
    begin
        sample_t       smp;
        board_result_t want;
        board_result_t got;
        listed_note_t  note;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                smp.op            = s_tuser;
                smp.now_ms        = s_tdata[31:0];
                smp.reading_valid = s_tdata[32];
                smp.length_q8     = s_tdata[48:33];
                want = qualify_sample(smp);
                note = listed_notes.pop_front();
                if (note.listed)
                    want = note.value;
                board_results_due.push_back(want);
            end
            if (m_tvalid && m_tready)
            begin
                got.add_event    = m_tuser;
                got.added_length = m_tdata[15:0];
                got.tracking     = m_tdata[16];
                got.clear_seen   = m_tdata[17];
                if (board_results_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result beat with nothing expected: add=%0b len=%0d",
                                 $realtime, got.add_event, $signed(got.added_length));
                end
                else
                begin
                    want = board_results_due.pop_front();
                    if (got != want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: mismatch, expected add=%0b len=%0d tracking=%0b ",
                                      "clear=%0b, got add=%0b len=%0d tracking=%0b clear=%0b"},
                                     $realtime, want.add_event, $signed(want.added_length),
                                     want.tracking, want.clear_seen, got.add_event,
                                     $signed(got.added_length), got.tracking, got.clear_seen);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= StallLimit)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int hold;
        m_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            hold = m_steady ? 0 : int'($urandom_range(0, 3));
            if ($urandom_range(0, 29) == 0)
                m_steady = !m_steady;
            if (hold != 0)
            begin
                m_tready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
        end
    end

    initial
    begin
        stim_row_t row;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        mismatches   = 0;
        quiet_cycles = 0;
        s_steady     = 1'b0;
        m_steady     = 1'b0;
        reset_qualifier_model();
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < NumRows; i++)
        begin
            row = StimTable[i];
            send_item(row.op, row.now_ms, row.reading_valid, row.length_q8,
                      row.listed, row.result);
        end
        for (int phase = 0; phase < NumPhases; phase++)
        begin
            settle_input();
            load_settings(phase);
            run_random_phase(ItemsPerPhase);
        end
        settle_input();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && board_results_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: filelist.f
design/slaaq_pkg.sv
design/stable_length_auto_add_qualifier_top.sv
design/slaaq_checker.sv
tb/sv/stable_length_auto_add_qualifier_top_test.sv
